>>> rtl/rlirs_pkg.sv
// Shared types and constants for the receiver bring-up sequencer.
// Used by the result channel interface, the config register block and the sequencer core.
package rlirs_pkg;

    localparam int unsigned HOLD_TICKS_W    = 8;
    localparam int unsigned ALIGN_TIMEOUT_W = 16;
    localparam int unsigned RETRY_LIMIT_W   = 4;
    localparam int unsigned RETRIES_W       = 4;
    localparam int unsigned CFG_DATA_W      = 16;
    localparam int unsigned CFG_IDX_W       = 2;

    localparam int unsigned WAIT_COUNT_BITS_DEF = 16;

    localparam logic [HOLD_TICKS_W-1:0]    HOLD_TICKS_RST    = 8'd1;
    localparam logic [ALIGN_TIMEOUT_W-1:0] ALIGN_TIMEOUT_RST = 16'd10000;
    localparam logic [RETRY_LIMIT_W-1:0]   RETRY_LIMIT_RST   = 4'd5;
    localparam logic [RETRIES_W-1:0]       RETRIES_MAX       = 4'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_TICKS    = 2'd0,
        CFG_ALIGN_TIMEOUT = 2'd1,
        CFG_RETRY_LIMIT   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [HOLD_TICKS_W-1:0]    hold_ticks;
        logic [ALIGN_TIMEOUT_W-1:0] align_timeout;
        logic [RETRY_LIMIT_W-1:0]   retry_limit;
    } t_cfg;

    typedef struct packed {
        logic                 rx_reset;
        logic                 busy_res;
        logic                 succeeded;
        logic                 failed;
        logic [RETRIES_W-1:0] retries_used;
    } t_result;

endpackage

>>> rtl/rlirs_in_if.sv
// Input channel of the bring-up sequencer: one tick word per transfer.
// Depends on nothing.
interface rlirs_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic link_up;

    modport source (output valid, output start_req, output link_up, input ready);
    modport sink   (input valid, input start_req, input link_up, output ready);
endinterface

>>> rtl/rlirs_out_if.sv
// Result channel of the bring-up sequencer: one status word per tick.
// Depends on rlirs_pkg for field widths.
interface rlirs_out_if
    import rlirs_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 rx_reset;
    logic                 busy_res;
    logic                 succeeded;
    logic                 failed;
    logic [RETRIES_W-1:0] retries_used;

    modport source (output valid, output rx_reset, output busy_res, output succeeded,
                    output failed, output retries_used, input ready);
    modport sink   (input valid, input rx_reset, input busy_res, input succeeded,
                    input failed, input retries_used, output ready);
endinterface

>>> rtl/rlirs_cfg.sv
// Configuration registers of the bring-up sequencer (write-only port).
// Depends on rlirs_pkg.
module rlirs_cfg
    import rlirs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ticks    <= HOLD_TICKS_RST;
            r_cfg.align_timeout <= ALIGN_TIMEOUT_RST;
            r_cfg.retry_limit   <= RETRY_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_HOLD_TICKS: begin
                    r_cfg.hold_ticks <= i_cfg_data[HOLD_TICKS_W-1:0];
                end
                CFG_ALIGN_TIMEOUT: begin
                    r_cfg.align_timeout <= i_cfg_data[ALIGN_TIMEOUT_W-1:0];
                end
                CFG_RETRY_LIMIT: begin
                    r_cfg.retry_limit <= i_cfg_data[RETRY_LIMIT_W-1:0];
                end
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/rlirs_seq.sv
// Sequencer core: phase machine, hold/wait counters and retry count,
// updated once per accepted tick word, with a registered result stage.
// Depends on rlirs_pkg, rlirs_in_if and rlirs_out_if.
module rlirs_seq
    import rlirs_pkg::*;
#(
    parameter int unsigned WAIT_COUNT_BITS = WAIT_COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    rlirs_in_if.sink    in_ch,
    rlirs_out_if.source out_ch
);

    localparam int unsigned CMP_W =
        (WAIT_COUNT_BITS > ALIGN_TIMEOUT_W) ? WAIT_COUNT_BITS : ALIGN_TIMEOUT_W;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HOLD = 2'd1,
        PH_WAIT = 2'd2
    } t_phase;

    t_phase                     r_phase,     n_phase;
    logic [HOLD_TICKS_W-1:0]    r_hold_cnt,  n_hold_cnt;
    logic [WAIT_COUNT_BITS-1:0] r_wait_cnt,  n_wait_cnt;
    logic [RETRIES_W-1:0]       r_fails,     n_fails;
    logic                       r_out_valid;
    t_result                    r_res,       n_res;

    logic                       accept;
    logic                       ok;
    logic                       bad;
    logic [WAIT_COUNT_BITS-1:0] wait_inc;
    logic [RETRIES_W-1:0]       fails_inc;
    logic                       timeout;

    assign in_ch.ready = !r_out_valid || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    // saturating wait counter; hitting its ceiling is a timeout too
    assign wait_inc  = (r_wait_cnt == '1) ? r_wait_cnt : r_wait_cnt + 1'b1;
    assign timeout   = (CMP_W'(wait_inc) >= CMP_W'(i_cfg.align_timeout))
                       || (wait_inc == '1);
    assign fails_inc = (r_fails == RETRIES_MAX) ? r_fails : r_fails + 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_hold_cnt = r_hold_cnt;
        n_wait_cnt = r_wait_cnt;
        n_fails    = r_fails;
        ok         = 1'b0;
        bad        = 1'b0;
        case (r_phase)
            PH_HOLD: begin
                if (r_hold_cnt >= i_cfg.hold_ticks) begin
                    n_phase    = PH_WAIT;
                    n_wait_cnt = '0;
                end else begin
                    n_hold_cnt = r_hold_cnt + 1'b1;
                end
            end
            PH_WAIT: begin
                if (in_ch.link_up) begin
                    ok      = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_wait_cnt = wait_inc;
                    if (timeout) begin
                        n_fails = fails_inc;
                        if (fails_inc >= i_cfg.retry_limit) begin
                            bad     = 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            // restart: reset asserts on this same tick
                            n_phase    = PH_HOLD;
                            n_hold_cnt = HOLD_TICKS_W'(1);
                            n_wait_cnt = '0;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (in_ch.start_req) begin
                    n_fails    = '0;
                    n_phase    = PH_HOLD;
                    n_hold_cnt = HOLD_TICKS_W'(1);
                    n_wait_cnt = '0;
                end
            end
        endcase

        n_res.rx_reset     = (n_phase == PH_HOLD);
        n_res.busy_res     = (n_phase != PH_IDLE);
        n_res.succeeded    = ok;
        n_res.failed       = bad;
        n_res.retries_used = n_fails;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_hold_cnt  <= '0;
            r_wait_cnt  <= '0;
            r_fails     <= '0;
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_hold_cnt  <= n_hold_cnt;
            r_wait_cnt  <= n_wait_cnt;
            r_fails     <= n_fails;
            r_out_valid <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, loaded with each accepted word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign out_ch.valid        = r_out_valid;
    assign out_ch.rx_reset     = r_res.rx_reset;
    assign out_ch.busy_res     = r_res.busy_res;
    assign out_ch.succeeded    = r_res.succeeded;
    assign out_ch.failed       = r_res.failed;
    assign out_ch.retries_used = r_res.retries_used;

`ifndef SYNTH
    a_pulse_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.succeeded && r_res.failed))
        else $error("success and failure pulses on the same word");

    a_reset_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.rx_reset |-> r_res.busy_res)
        else $error("receiver reset asserted while not busy");

    a_start_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && in_ch.start_req && r_phase != PH_HOLD && r_phase != PH_WAIT
        |=> r_phase == PH_HOLD && r_fails == '0)
        else $error("start in idle did not enter reset hold");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_phase) && $stable(r_fails) && $stable(r_wait_cnt))
        else $error("state moved without an accepted word");

    a_fail_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.failed |-> r_res.retries_used != '0)
        else $error("failure reported with no failed attempt");
`endif

endmodule

>>> rtl/rx_link_init_retry_sequencer_core.sv
// Channel   | Dir | Fields                                           | Handshake
// i_in_ch   | in  | start_req, link_up                               | valid/ready
// o_out_ch  | out | rx_reset, busy_res, succeeded, failed, retries_used | valid/ready
// i_cfg_*   | in  | idx 0 hold_ticks, 1 align_timeout, 2 retry_limit | write enable
//
// One tick word per clock while the result register can take it; its status word appears
// in the result register on the next cycle.
// Input is taken whenever the result register is empty or drained in the same cycle.
// Synchronous active-low reset returns to idle with default config values.
// Top level of the receiver bring-up sequencer; depends on rlirs_pkg,
// rlirs_in_if, rlirs_out_if, rlirs_cfg and rlirs_seq.
module rx_link_init_retry_sequencer_core
    import rlirs_pkg::*;
#(
    parameter int unsigned WAIT_COUNT_BITS = WAIT_COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rlirs_in_if.sink              i_in_ch,
    rlirs_out_if.source           o_out_ch
);

    t_cfg cfg;

    rlirs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rlirs_seq #(
        .WAIT_COUNT_BITS (WAIT_COUNT_BITS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .in_ch   (i_in_ch),
        .out_ch  (o_out_ch)
    );

endmodule

>>> bench/rlirs_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the receiver bring-up sequencer: follows register writes, predicts the
// status word of every accepted tick word and compares it with the result channel.
// Depends on rlirs_pkg, rlirs_in_if and rlirs_out_if.
module rlirs_checker
    import rlirs_pkg::*;
#(
    parameter int unsigned WAIT_COUNT_BITS = WAIT_COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rlirs_in_if                   i_in_ch,
    rlirs_out_if                  i_out_ch,
    output int unsigned           o_fail_count,
    output int unsigned           o_pending,
    output logic                  o_seq_busy,
    output int unsigned           o_words_checked,
    output int unsigned           o_ok_count,
    output int unsigned           o_gave_up_count
);

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_HOLD = 2'd1,
        SEQ_WAIT = 2'd2
    } t_seq_phase;

    localparam logic [WAIT_COUNT_BITS-1:0] WAIT_MAX = '1;

    logic [HOLD_TICKS_W-1:0]    cfg_hold;
    logic [ALIGN_TIMEOUT_W-1:0] cfg_timeout;
    logic [RETRY_LIMIT_W-1:0]   cfg_retry;

    t_seq_phase                 seq_ph;
    logic [HOLD_TICKS_W-1:0]    hold_cnt;
    logic [WAIT_COUNT_BITS-1:0] wait_cnt;
    logic [RETRIES_W-1:0]       attempt_fails;

    t_result     status_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned oks;
    int unsigned gave_up;

    function automatic void start_attempt();
        seq_ph   = SEQ_HOLD;
        hold_cnt = HOLD_TICKS_W'(1);
        wait_cnt = '0;
    endfunction

    // Advance the sequencer by one tick and return the status word it shows afterwards.
    function automatic t_result bringup_tick(input logic start, input logic link);
        t_result r;
        r = '0;
        case (seq_ph)
            SEQ_HOLD: begin
                if (hold_cnt >= cfg_hold) begin
                    seq_ph   = SEQ_WAIT;
                    wait_cnt = '0;
                end else begin
                    hold_cnt = hold_cnt + 1'b1;
                end
            end
            SEQ_WAIT: begin
                if (link) begin
                    r.succeeded = 1'b1;
                    seq_ph      = SEQ_IDLE;
                end else begin
                    if (wait_cnt != WAIT_MAX)
                        wait_cnt = wait_cnt + 1'b1;
                    // a saturated counter times out even above the programmed limit
                    if (wait_cnt >= cfg_timeout || wait_cnt == WAIT_MAX) begin
                        if (attempt_fails != RETRIES_MAX)
                            attempt_fails = attempt_fails + 1'b1;
                        if (attempt_fails >= cfg_retry) begin
                            r.failed = 1'b1;
                            seq_ph   = SEQ_IDLE;
                        end else begin
                            start_attempt();
                        end
                    end
                end
            end
            default: begin
                seq_ph = SEQ_IDLE;
                if (start) begin
                    attempt_fails = '0;
                    start_attempt();
                end
            end
        endcase
        r.rx_reset     = (seq_ph == SEQ_HOLD);
        r.busy_res     = (seq_ph != SEQ_IDLE);
        r.retries_used = attempt_fails;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg_hold      = HOLD_TICKS_RST;
            cfg_timeout   = ALIGN_TIMEOUT_RST;
            cfg_retry     = RETRY_LIMIT_RST;
            seq_ph        = SEQ_IDLE;
            hold_cnt      = '0;
            wait_cnt      = '0;
            attempt_fails = '0;
            status_q.delete();
            mismatches    = 0;
            checked       = 0;
            oks           = 0;
            gave_up       = 0;
        end else begin
            // compare the outgoing word before queuing the one coming in
            if (i_out_ch.valid && i_out_ch.ready) begin
                got = {i_out_ch.rx_reset, i_out_ch.busy_res, i_out_ch.succeeded,
                       i_out_ch.failed, i_out_ch.retries_used};
                if (status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("%0t: status word with nothing expected:", $realtime);
                        $display(" rst=%b busy=%b ok=%b fail=%b retries=%0d",
                                 got.rx_reset, got.busy_res, got.succeeded,
                                 got.failed, got.retries_used);
                    end
                end else begin
                    want = status_q.pop_front();
                    checked++;
                    if (got.rx_reset !== want.rx_reset || got.busy_res !== want.busy_res ||
                        got.succeeded !== want.succeeded || got.failed !== want.failed ||
                        got.retries_used !== want.retries_used) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("%0t: status word %0d: expected rst=%b busy=%b ok=%b",
                                   $realtime, checked, want.rx_reset, want.busy_res,
                                   want.succeeded);
                            $write(" fail=%b retries=%0d,", want.failed,
                                   want.retries_used);
                            $display(" got rst=%b busy=%b ok=%b fail=%b retries=%0d",
                                     got.rx_reset, got.busy_res, got.succeeded,
                                     got.failed, got.retries_used);
                        end
                    end
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                want = bringup_tick(i_in_ch.start_req, i_in_ch.link_up);
                status_q.push_back(want);
                if (want.succeeded)
                    oks++;
                if (want.failed)
                    gave_up++;
            end
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_HOLD_TICKS:    cfg_hold    = i_cfg_data[HOLD_TICKS_W-1:0];
                    CFG_ALIGN_TIMEOUT: cfg_timeout = i_cfg_data[ALIGN_TIMEOUT_W-1:0];
                    CFG_RETRY_LIMIT:   cfg_retry   = i_cfg_data[RETRY_LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count    <= mismatches;
        o_pending       <= status_q.size();
        o_seq_busy      <= (seq_ph != SEQ_IDLE);
        o_words_checked <= checked;
        o_ok_count      <= oks;
        o_gave_up_count <= gave_up;
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Top of the bring-up sequencer bench: clock, reset, register writes and tick-word stimulus
// with random idling on both channels. Depends on rlirs_pkg, the two channel interfaces,
// rx_link_init_retry_sequencer_core and rlirs_checker.
module testbench;
    import rlirs_pkg::*;

    localparam int unsigned PHASE_WORDS = 180;
    localparam int unsigned HOLD_OFF_CYCLES = 200;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned fail_count;
    int unsigned pending;
    logic        seq_busy;
    int unsigned words_checked;
    int unsigned ok_count;
    int unsigned gave_up_count;

    int unsigned words_sent;
    int unsigned settings_used;
    int unsigned hold_eff;
    int unsigned tmo_eff;
    int unsigned retry_eff;
    bit          quiet;
    bit          hold_off_req;

    rlirs_in_if  in_ch ();
    rlirs_out_if out_ch ();

    rx_link_init_retry_sequencer_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    rlirs_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_ch        (in_ch),
        .i_out_ch       (out_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_seq_busy     (seq_busy),
        .o_words_checked(words_checked),
        .o_ok_count     (ok_count),
        .o_gave_up_count(gave_up_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_tick(input logic start, input logic link);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.start_req <= start;
        in_ch.link_up   <= link;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
    endtask

    // Bring the sequencer back to idle (link up ends any wait) and let all words drain.
    task automatic drain_sequencer();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (seq_busy) begin
            send_tick(1'b0, 1'b1);
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apply_setting(input int unsigned h, input int unsigned t,
                                 input int unsigned r);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= CFG_HOLD_TICKS;
        cfg_data  <= CFG_DATA_W'(h & 32'hFF);
        @(posedge i_clk);
        cfg_idx   <= CFG_ALIGN_TIMEOUT;
        cfg_data  <= CFG_DATA_W'(t & 32'hFFFF);
        @(posedge i_clk);
        cfg_idx   <= CFG_RETRY_LIMIT;
        cfg_data  <= CFG_DATA_W'(r & 32'hF);
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        hold_eff  = (h == 0) ? 1 : h;
        tmo_eff   = (t == 0) ? 1 : t;
        retry_eff = (r == 0) ? 1 : r;
        settings_used++;
    endtask

    task automatic run_phase(input int unsigned h, input int unsigned t,
                             input int unsigned r, input bit squeeze);
        int unsigned first_word;
        int unsigned span;
        int unsigned ticks;
        bit          land;
        drain_sequencer();
        apply_setting(h, t, r);
        if (squeeze)
            hold_off_req = 1'b1;
        first_word = words_sent;
        while (words_sent - first_word < PHASE_WORDS) begin
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7) begin
                // start, then a stretch of link down, usually ending with link up
                send_tick(1'b1, 1'($urandom_range(0, 1)));
                span = (hold_eff + 1 + tmo_eff) * retry_eff + 3;
                if (span > 300)
                    span = 300;
                ticks = $urandom_range(0, span);
                land  = ($urandom_range(0, 2) != 0);
                repeat (ticks)
                    send_tick($urandom_range(0, 15) == 0, $urandom_range(0, 63) == 0);
                if (land)
                    send_tick(1'b0, 1'b1);
                repeat ($urandom_range(0, 3))
                    send_tick(1'b0, 1'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(1, 8))
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Result side: random stalls per word, plus one long hold-off on request.
    initial begin
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            if (!quiet && $urandom_range(0, 12) != 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_idx         <= CFG_HOLD_TICKS;
        cfg_data        <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.start_req <= 1'b0;
        in_ch.link_up   <= 1'b0;
        words_sent    = 0;
        settings_used = 1;
        hold_eff      = HOLD_TICKS_RST;
        tmo_eff       = ALIGN_TIMEOUT_RST;
        retry_eff     = RETRY_LIMIT_RST;
        quiet         = 1'b0;
        hold_off_req  = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default registers: link up while idle, starts and link up while busy, success
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);

        // all-zero registers act as one: first timeout gives up at once
        drain_sequencer();
        apply_setting(0, 0, 0);
        send_tick(1'b1, 1'b0);
        repeat (3) send_tick(1'b0, 1'b0);

        // two attempts time out, then failure
        drain_sequencer();
        apply_setting(2, 3, 2);
        send_tick(1'b1, 1'b0);
        repeat (10) send_tick(1'b0, 1'b0);

        run_phase(255, 65535, 15, 1'b0);
        run_phase(1, 1, 1, 1'b1);
        run_phase(0, 0, 0, 1'b0);
        run_phase(1, 3, 15, 1'b0);
        repeat (4)
            run_phase($urandom_range(0, 6), $urandom_range(0, 12), $urandom_range(0, 15), 1'b0);

        drain_sequencer();
        repeat (5) @(posedge i_clk);
        $display("Sent %0d tick words under %0d register settings, %0d status words checked.",
                 words_sent, settings_used, words_checked);
        $display("Predicted %0d successful bring-ups and %0d exhausted retry runs.",
                 ok_count, gave_up_count);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/rlirs_pkg.sv
rtl/rlirs_in_if.sv
rtl/rlirs_out_if.sv
rtl/rlirs_cfg.sv
rtl/rlirs_seq.sv
rtl/rx_link_init_retry_sequencer_core.sv
bench/rlirs_checker.sv
bench/testbench.sv
